### sv/dfuseq_pkg.sv
// shared types and constants for the dfu download flash sequencer
package dfuseq_pkg;

    // request kind carried in the slave-side tuser
    typedef enum logic [1:0] {
        KIND_DNLOAD    = 2'd0,
        KIND_GETSTATUS = 2'd1,
        KIND_CLRSTATUS = 2'd2,
        KIND_ABORT     = 2'd3
    } t_kind;

    // dfu protocol state as reported to the host
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DNSYNC   = 3'd1,
        ST_DNBUSY   = 3'd2,
        ST_DNIDLE   = 3'd3,
        ST_MSYNC    = 3'd4,
        ST_MANIFEST = 3'd5,
        ST_ERROR    = 3'd6
    } t_dfu_state;

    // dfu status codes
    typedef enum logic [2:0] {
        SC_OK      = 3'd0,
        SC_ADDRESS = 3'd1,
        SC_STALLED = 3'd2,
        SC_UNKNOWN = 3'd3,
        SC_ERASE   = 3'd4,
        SC_VERIFY  = 3'd5
    } t_status;

    // flash engine phase
    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_ERASING     = 2'd1,
        PH_PROGRAMMING = 2'd2
    } t_phase;

    // flash command kind
    typedef enum logic {
        CMD_ERASE   = 1'b0,
        CMD_PROGRAM = 1'b1
    } t_cmd;

    // flash status bit positions
    localparam int FS_DONE   = 4;
    localparam int FS_RDCOL  = 3;
    localparam int FS_ACCERR = 2;
    localparam int FS_FPVIOL = 1;
    localparam int FS_CMDERR = 0;

    localparam logic [16:0] SECTOR_BASE   = 17'h01000;
    localparam logic [9:0]  TIMEOUT_SHORT = 10'd1;
    localparam logic [9:0]  TIMEOUT_LONG  = 10'd1000;

endpackage

### sv/dfu_download_flash_sequencer.sv
// dfu download sequencer: block buffer, protocol state and flash erase/program issue
//
//  channel  | dir | tdata fields (low bit first)                      | tuser / tlast
//  ---------+-----+---------------------------------------------------+---------------------
//  s_axis   | in  | block_num, block_length, packet_offset,           | tuser: kind
//           |     | packet_length, byte_index, data_byte, flash_status| tlast: last_of_packet
//  m_axis   | out | ok, status_code, poll_timeout, dfu_state_out,     | tuser: cmd_valid,
//           |     | cmd_address, cmd_data                             |        cmd_kind
//
// one transaction in, one transaction out; a new transaction can be taken every
// cycle while m_axis is not stalled; the path runs through an input register, then
// a result register that also captures the registered read of one buffer longword
// for a program command; after reset a clearing pass zeroes the buffer one longword
// per cycle, all (TRANSFER_SIZE+3)/4 rows, with s_axis tready low
// a stalled result holds in the output register; the input register still takes one
// more transaction behind it
module dfu_download_flash_sequencer #(
    parameter int TRANSFER_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // block_num[5:0] block_length[16:6] packet_offset[27:17] packet_length[38:28]
    // byte_index[48:39] data_byte[56:49] flash_status[61:57], zero above
    input  logic [63:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // ok[0] status_code[3:1] poll_timeout[13:4] dfu_state_out[16:14]
    // cmd_address[33:17] cmd_data[65:34], zero above
    output logic [71:0] o_m_axis_tdata,
    // cmd_valid[0] cmd_kind[1]
    output logic [1:0]  o_m_axis_tuser
);
    import dfuseq_pkg::*;

    // buffer is organized as longword rows with a byte lane per write
    localparam int ROWS   = (TRANSFER_SIZE + 3) / 4;
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW_MIN = $clog2(TRANSFER_SIZE + 4);
    localparam int PW     = (PW_MIN > RW + 2) ? PW_MIN : RW + 2;
    localparam logic [12:0]   TS_13   = 13'(TRANSFER_SIZE);
    localparam logic [PW-1:0] TS_P    = PW'(TRANSFER_SIZE);
    localparam logic [RW-1:0] ROW_TOP = RW'(ROWS - 1);

    // buffer memory
    logic [3:0][7:0] r_mem [ROWS];

    // clearing pass
    logic          r_clr_busy;
    logic [RW-1:0] r_clr_row;

    // input register
    logic        r_a_valid;
    t_kind       r_a_kind;
    logic [5:0]  r_a_bnum;
    logic [10:0] r_a_blen;
    logic [10:0] r_a_poff;
    logic [10:0] r_a_plen;
    logic [9:0]  r_a_bidx;
    logic [7:0]  r_a_data;
    logic        r_a_last;
    logic [4:0]  r_a_fs;

    // protocol and flash engine state
    t_dfu_state    r_state,    n_state;
    t_status       r_status,   n_status;
    logic          r_long_to,  n_long_to;
    t_phase        r_phase,    n_phase;
    logic [16:0]   r_sector,   n_sector;
    logic [PW-1:0] r_prog_off, n_prog_off;

    // result register
    logic        r_b_valid;
    logic        r_b_ok;
    t_status     r_b_status;
    logic [9:0]  r_b_timeout;
    t_dfu_state  r_b_state;
    logic        r_b_cmd_valid;
    t_cmd        r_b_cmd_kind;
    logic [16:0] r_b_cmd_addr;
    logic [31:0] r_b_cmd_data;

    logic a_fire;
    logic in_accept;

    // decode of the item in the input register
    logic          is_dl, is_poll, is_clr;
    logic [11:0]   end_sum;
    logic [11:0]   pos;
    logic          ovf, store, completes, bad_state, flash_busy;
    logic          in_dn, fs_err, fs_good, poll_act, poll_err;
    logic          prog_first, prog_more, prog_finish, launch_erase, launch_prog;
    logic          off_below;
    logic [PW-1:0] off_sel;
    logic [16:0]   erase_addr;
    t_status       flash_err_code;

    // result-side values
    logic        res_ok;
    logic        res_cmd_valid;
    t_cmd        res_cmd_kind;
    logic [16:0] res_cmd_addr;

    assign a_fire          = r_a_valid && (!r_b_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_clr_busy && (!r_a_valid || a_fire);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign is_dl   = (r_a_kind == KIND_DNLOAD);
    assign is_poll = (r_a_kind == KIND_GETSTATUS);
    assign is_clr  = (r_a_kind == KIND_CLRSTATUS);

    // download checks
    assign end_sum    = {1'b0, r_a_poff} + {1'b0, r_a_plen};
    assign pos        = {1'b0, r_a_poff} + {2'b00, r_a_bidx};
    assign ovf        = ({1'b0, end_sum} > TS_13) || (end_sum > {1'b0, r_a_blen});
    assign store      = is_dl && !ovf && ({1'b0, r_a_bidx} < r_a_plen)
                        && ({1'b0, pos} < TS_13);
    assign completes  = r_a_last && (end_sum == {1'b0, r_a_blen});
    assign bad_state  = (r_state != ST_IDLE) && (r_state != ST_DNIDLE);
    assign flash_busy = !r_a_fs[FS_DONE] || (r_phase != PH_IDLE);
    assign launch_erase = is_dl && !ovf && completes && !bad_state && !flash_busy
                          && (r_a_blen != 11'd0);
    assign erase_addr = SECTOR_BASE + {1'b0, r_a_bnum, 10'd0};

    // status poll against the flash engine
    assign in_dn    = (r_state == ST_DNSYNC) || (r_state == ST_DNBUSY);
    assign fs_err   = r_a_fs[FS_DONE] && (r_a_fs[3:0] != 4'd0);
    assign fs_good  = r_a_fs[FS_DONE] && (r_a_fs[3:0] == 4'd0);
    assign poll_act = is_poll && in_dn;
    assign poll_err = poll_act && fs_err && (r_phase != PH_IDLE);
    assign off_below   = (r_prog_off < TS_P);
    assign prog_first  = poll_act && fs_good && (r_phase == PH_ERASING);
    assign prog_more   = poll_act && fs_good && (r_phase == PH_PROGRAMMING) && off_below;
    assign prog_finish = poll_act && fs_good && (r_phase == PH_PROGRAMMING) && !off_below;
    assign launch_prog = prog_first || prog_more;
    // first longword goes out with the erase completion, the rest follow from offset 4
    assign off_sel     = prog_first ? '0 : r_prog_off;

    always_comb begin
        priority if (r_a_fs[FS_RDCOL]) begin
            flash_err_code = SC_UNKNOWN;
        end else if (r_a_fs[FS_ACCERR] || r_a_fs[FS_FPVIOL]) begin
            flash_err_code = SC_ADDRESS;
        end else if (r_phase == PH_ERASING) begin
            flash_err_code = SC_ERASE;
        end else begin
            flash_err_code = SC_VERIFY;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_long_to  = r_long_to;
        n_phase    = r_phase;
        n_sector   = r_sector;
        n_prog_off = r_prog_off;
        unique case (r_a_kind)
            KIND_DNLOAD: begin
                priority if (ovf) begin
                    n_state  = ST_ERROR;
                    n_status = SC_ADDRESS;
                end else if (!completes) begin
                    n_state = r_state;
                end else if (bad_state) begin
                    n_state  = ST_ERROR;
                    n_status = SC_STALLED;
                end else if (flash_busy) begin
                    n_state  = ST_ERROR;
                    n_status = SC_UNKNOWN;
                end else if (r_a_blen == 11'd0) begin
                    n_state  = ST_MSYNC;
                    n_status = SC_OK;
                end else begin
                    n_phase  = PH_ERASING;
                    n_sector = erase_addr;
                    n_state  = ST_DNSYNC;
                    n_status = SC_OK;
                end
            end
            KIND_GETSTATUS: begin
                if (in_dn) begin
                    if (poll_err) begin
                        n_state  = ST_ERROR;
                        n_status = flash_err_code;
                        n_phase  = PH_IDLE;
                    end else begin
                        if (prog_first) begin
                            n_phase    = PH_PROGRAMMING;
                            n_prog_off = PW'(4);
                        end
                        if (prog_more) begin
                            n_prog_off = r_prog_off + PW'(4);
                        end
                        if (prog_finish) begin
                            n_phase = PH_IDLE;
                        end
                        n_state = (n_phase == PH_IDLE) ? ST_DNIDLE : ST_DNBUSY;
                    end
                end else if (r_state == ST_MSYNC) begin
                    n_state   = ST_MANIFEST;
                    n_long_to = 1'b1;
                end
            end
            KIND_CLRSTATUS: begin
                if (r_state == ST_ERROR) begin
                    n_state  = ST_IDLE;
                    n_status = SC_OK;
                end else begin
                    n_state  = ST_ERROR;
                    n_status = SC_STALLED;
                end
            end
            KIND_ABORT: begin
                n_state  = ST_IDLE;
                n_status = SC_OK;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // result and command
    always_comb begin
        res_ok        = 1'b1;
        res_cmd_valid = 1'b0;
        res_cmd_kind  = CMD_ERASE;
        res_cmd_addr  = '0;
        if (is_dl) begin
            res_ok = !(ovf || (completes && (bad_state || flash_busy)));
        end
        if (is_clr) begin
            res_ok = (r_state == ST_ERROR);
        end
        if (launch_erase) begin
            res_cmd_valid = 1'b1;
            res_cmd_kind  = CMD_ERASE;
            res_cmd_addr  = erase_addr;
        end
        if (launch_prog) begin
            res_cmd_valid = 1'b1;
            res_cmd_kind  = CMD_PROGRAM;
            res_cmd_addr  = r_sector + 17'(off_sel);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_state    <= ST_IDLE;
            r_status   <= SC_OK;
            r_long_to  <= 1'b0;
            r_phase    <= PH_IDLE;
            r_sector   <= '0;
            r_prog_off <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + RW'(1);
                if (r_clr_row == ROW_TOP) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid  <= 1'b1;
                r_state    <= n_state;
                r_status   <= n_status;
                r_long_to  <= n_long_to;
                r_phase    <= n_phase;
                r_sector   <= n_sector;
                r_prog_off <= n_prog_off;
            end else if (i_m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_kind <= t_kind'(i_s_axis_tuser);
            r_a_bnum <= i_s_axis_tdata[5:0];
            r_a_blen <= i_s_axis_tdata[16:6];
            r_a_poff <= i_s_axis_tdata[27:17];
            r_a_plen <= i_s_axis_tdata[38:28];
            r_a_bidx <= i_s_axis_tdata[48:39];
            r_a_data <= i_s_axis_tdata[56:49];
            r_a_last <= i_s_axis_tlast;
            r_a_fs   <= i_s_axis_tdata[61:57];
        end
        if (a_fire) begin
            r_b_ok        <= res_ok;
            r_b_status    <= n_status;
            r_b_timeout   <= n_long_to ? TIMEOUT_LONG : TIMEOUT_SHORT;
            r_b_state     <= n_state;
            r_b_cmd_valid <= res_cmd_valid;
            r_b_cmd_kind  <= res_cmd_kind;
            r_b_cmd_addr  <= res_cmd_addr;
        end
    end

    // buffer: clearing pass, byte-lane writes, registered longword read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (a_fire && store) begin
            r_mem[pos[RW+1:2]][pos[1:0]] <= r_a_data;
        end
        if (a_fire) begin
            r_b_cmd_data <= launch_prog ? r_mem[off_sel[RW+1:2]] : '0;
        end
    end

    assign o_m_axis_tvalid = r_b_valid;
    assign o_m_axis_tdata  = {6'd0, r_b_cmd_data, r_b_cmd_addr, r_b_state, r_b_timeout,
                              r_b_status, r_b_ok};
    assign o_m_axis_tuser  = {r_b_cmd_kind, r_b_cmd_valid};

    // a launched command always belongs to an accepted request
    a_cmd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_cmd_valid) |-> r_b_ok)
        else $error("flash command issued on a stalled request");

    // an erase leaves the protocol in dnload sync
    a_erase_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_cmd_valid && (r_b_cmd_kind == CMD_ERASE))
        |-> (r_b_state == ST_DNSYNC))
        else $error("erase issued outside dnload sync");

    // program offset stays longword aligned
    a_off_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog_off[1:0] == 2'b00)
        else $error("program offset misaligned");

    // the error state always carries a failure status
    a_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERROR) |-> (r_status != SC_OK))
        else $error("error state with ok status");

    // no request is taken while the buffer is being cleared
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_a_valid && !r_b_valid))
        else $error("request in flight during buffer clear");

endmodule
